FILE: hdl/rcpnr_pkg.sv
// Package: shared types and constants for the RGB channel pack resampler.
package rcpnr_pkg;

    localparam int MAX_DIM_DEF   = 4096;
    localparam int SCALE_FB_DEF  = 16;
    localparam int DIM_W         = 13;
    localparam int IDX_W         = 24;
    localparam int BYTE_W        = 8;
    localparam int NCH           = 3;

    localparam logic MODE_START   = 1'b0;
    localparam logic MODE_SAMPLES = 1'b1;
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_PIXEL   = 1'b1;

    localparam logic [2:0] REG_RED_W    = 3'd0;
    localparam logic [2:0] REG_RED_H    = 3'd1;
    localparam logic [2:0] REG_GREEN_W  = 3'd2;
    localparam logic [2:0] REG_GREEN_H  = 3'd3;
    localparam logic [2:0] REG_BLUE_W   = 3'd4;
    localparam logic [2:0] REG_BLUE_H   = 3'd5;
    localparam logic [2:0] REG_PRESENT  = 3'd6;
    localparam logic [2:0] REG_DEFAULT  = 3'd7;

    // controller -> datapath
    typedef struct packed {
        logic start_load;   // latch frame size, init dividers
        logic div_step;     // one restoring-division step on all channels
        logic idx_start;    // begin index computation for the current pixel
        logic idx_step;     // one index pipeline step
        logic advance;      // move to the next pixel
        logic out_pixel;    // load output with composed pixel
        logic out_request;  // load output with request
    } rc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;        // no source present
        logic div_done;
        logic idx_done;
        logic last;
    } rc_sts_t;

endpackage

FILE: hdl/rcpnr_datapath.sv
// Datapath: scale division, coordinate/index computation and output register.
module rcpnr_datapath
    import rcpnr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FB_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  rc_cmd_t              cmd,
    output rc_sts_t              sts,
    input  logic [DIM_W-1:0]     src_w_raw [NCH],
    input  logic [DIM_W-1:0]     src_h_raw [NCH],
    input  logic [2:0]           present,
    input  logic [23:0]          dflt,
    input  logic [BYTE_W-1:0]    red_sample,
    input  logic [BYTE_W-1:0]    green_sample,
    input  logic [BYTE_W-1:0]    blue_sample,
    output logic                 kind,
    output logic [IDX_W-1:0]     red_index,
    output logic [IDX_W-1:0]     green_index,
    output logic [IDX_W-1:0]     blue_index,
    output logic [BYTE_W-1:0]    out_red,
    output logic [BYTE_W-1:0]    out_green,
    output logic [BYTE_W-1:0]    out_blue,
    output logic                 last_pixel
);

    localparam int EW   = $clog2(MAX_DIM + 1);          // effective dimension width
    localparam int SW   = EW + SCALE_FRAC_BITS;          // scale / dividend width
    localparam int CW   = EW;                            // counter width
    localparam int PW   = CW + SW;                       // product width
    localparam int STW  = $clog2(SW + 1);

    function automatic logic [EW-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [EW-1:0] r;
        if (v == '0)
            r = EW'(1);
        else if (32'(v) > MAX_DIM)
            r = EW'(MAX_DIM);
        else
            r = EW'(v);
        return r;
    endfunction

    logic [EW-1:0] ew [NCH];
    logic [EW-1:0] eh [NCH];
    logic [EW-1:0] max_w, max_h;

    always_comb
    begin
        max_w = '0;
        max_h = '0;
        for (int c = 0; c < NCH; c++)
        begin
            ew[c] = eff_dim(src_w_raw[c]);
            eh[c] = eff_dim(src_h_raw[c]);
            if (present[c] && ew[c] > max_w)
                max_w = ew[c];
            if (present[c] && eh[c] > max_h)
                max_h = eh[c];
        end
    end

    logic [EW-1:0] fw_reg, fh_reg;
    logic [CW-1:0] col_reg, row_reg;
    logic [SW-1:0] sx_reg [NCH];
    logic [SW-1:0] sy_reg [NCH];
    logic [SW-1:0] rx_reg [NCH];
    logic [SW-1:0] ry_reg [NCH];
    logic [STW-1:0] dcnt_reg;

    // restoring division, one quotient bit per step, 6 dividers in parallel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg   <= '0;
            fh_reg   <= '0;
            col_reg  <= '0;
            row_reg  <= '0;
            dcnt_reg <= '0;
            for (int c = 0; c < NCH; c++)
            begin
                sx_reg[c] <= '0;
                sy_reg[c] <= '0;
                rx_reg[c] <= '0;
                ry_reg[c] <= '0;
            end
        end
        else if (cmd.start_load)
        begin
            fw_reg   <= max_w;
            fh_reg   <= max_h;
            col_reg  <= '0;
            row_reg  <= '0;
            dcnt_reg <= STW'(SW);
            for (int c = 0; c < NCH; c++)
            begin
                sx_reg[c] <= SW'(ew[c]) << SCALE_FRAC_BITS;
                sy_reg[c] <= SW'(eh[c]) << SCALE_FRAC_BITS;
                rx_reg[c] <= '0;
                ry_reg[c] <= '0;
            end
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg - STW'(1);
            for (int c = 0; c < NCH; c++)
            begin
                logic [SW:0] tx, ty;
                tx = {rx_reg[c], sx_reg[c][SW-1]};
                ty = {ry_reg[c], sy_reg[c][SW-1]};
                if (tx >= (SW+1)'(fw_reg))
                begin
                    rx_reg[c] <= SW'(tx - (SW+1)'(fw_reg));
                    sx_reg[c] <= {sx_reg[c][SW-2:0], 1'b1};
                end
                else
                begin
                    rx_reg[c] <= SW'(tx);
                    sx_reg[c] <= {sx_reg[c][SW-2:0], 1'b0};
                end
                if (ty >= (SW+1)'(fh_reg))
                begin
                    ry_reg[c] <= SW'(ty - (SW+1)'(fh_reg));
                    sy_reg[c] <= {sy_reg[c][SW-2:0], 1'b1};
                end
                else
                begin
                    ry_reg[c] <= SW'(ty);
                    sy_reg[c] <= {sy_reg[c][SW-2:0], 1'b0};
                end
            end
        end
        else if (cmd.advance)
        begin
            if (CW'(col_reg + CW'(1)) >= CW'(fw_reg) || col_reg + CW'(1) == '0)
            begin
                col_reg <= '0;
                row_reg <= row_reg + CW'(1);
            end
            else
                col_reg <= col_reg + CW'(1);
        end
    end

    logic last_w;
    assign last_w = ({1'b0, col_reg} + (CW+1)'(1) >= (CW+1)'(fw_reg)) &&
                    ({1'b0, row_reg} + (CW+1)'(1) >= (CW+1)'(fh_reg));

    // index pipeline: stage 0 products, stage 1 clamp, stage 2 row*width, stage 3 sum
    logic [PW-1:0] px_reg [NCH];
    logic [PW-1:0] py_reg [NCH];
    logic [EW-1:0] cx_reg [NCH];
    logic [EW-1:0] cy_reg [NCH];
    logic [2*EW-1:0] rw_reg [NCH];
    logic [IDX_W-1:0] idx_reg [NCH];
    logic [2:0] ist_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ist_reg <= '0;
        else if (cmd.idx_start)
            ist_reg <= 3'd1;
        else if (cmd.idx_step && ist_reg != 3'd4)
            ist_reg <= ist_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < NCH; c++)
        begin
            if (cmd.idx_start)
            begin
                px_reg[c] <= PW'(col_reg) * PW'(sx_reg[c]);
                py_reg[c] <= PW'(row_reg) * PW'(sy_reg[c]);
            end
            else if (cmd.idx_step)
            begin
                case (ist_reg)
                    3'd1:
                    begin
                        cx_reg[c] <= ((px_reg[c] >> SCALE_FRAC_BITS) >= PW'(ew[c])) ?
                                     ew[c] - EW'(1) : EW'(px_reg[c] >> SCALE_FRAC_BITS);
                        cy_reg[c] <= ((py_reg[c] >> SCALE_FRAC_BITS) >= PW'(eh[c])) ?
                                     eh[c] - EW'(1) : EW'(py_reg[c] >> SCALE_FRAC_BITS);
                    end
                    3'd2:
                        rw_reg[c] <= (2*EW)'(cy_reg[c]) * (2*EW)'(ew[c]);
                    3'd3:
                        idx_reg[c] <= IDX_W'(rw_reg[c] + (2*EW)'(cx_reg[c]));
                    default:
                        ;
                endcase
            end
        end
    end

    assign sts.empty    = (max_w == '0);
    assign sts.div_done = (dcnt_reg == '0);
    assign sts.idx_done = (ist_reg == 3'd4);
    assign sts.last     = last_w;

    logic last_q_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_q_reg <= 1'b0;
        else if (cmd.out_pixel)
            last_q_reg <= last_w;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_pixel)
        begin
            kind        <= KIND_PIXEL;
            red_index   <= '0;
            green_index <= '0;
            blue_index  <= '0;
            out_red     <= present[0] ? red_sample   : dflt[23:16];
            out_green   <= present[1] ? green_sample : dflt[15:8];
            out_blue    <= present[2] ? blue_sample  : dflt[7:0];
        end
        else if (cmd.out_request)
        begin
            kind        <= KIND_REQUEST;
            red_index   <= present[0] ? idx_reg[0] : '0;
            green_index <= present[1] ? idx_reg[1] : '0;
            blue_index  <= present[2] ? idx_reg[2] : '0;
            out_red     <= '0;
            out_green   <= '0;
            out_blue    <= '0;
        end
    end

    assign last_pixel = (kind == KIND_PIXEL) ? last_q_reg : 1'b0;

endmodule

FILE: hdl/rcpnr_ctrl.sv
// Controller: sequences division, index computation and the output of requests and pixels.
module rcpnr_ctrl
    import rcpnr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     in_mode,
    output logic     out_valid,
    input  logic     out_stall,
    output rc_cmd_t  cmd,
    input  rc_sts_t  sts
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_IDX   = 7'b0000100,
        S_WAIT  = 7'b0001000,
        S_SAMP  = 7'b0010000,
        S_PIX   = 7'b0100000,
        S_REQ   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   active_reg, active_next;
    logic   ov_reg, ov_next;
    logic   take;

    assign take      = in_valid && !in_stall;
    assign out_valid = ov_reg;

    always_comb
    begin
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE: in_stall = ov_reg;
            S_SAMP: in_stall = ov_reg;
            default: in_stall = 1'b1;
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        active_next = active_reg;
        ov_next     = ov_reg && out_stall;
        cmd         = '0;
        case (state_reg)
            S_IDLE, S_SAMP:
            begin
                if (take)
                begin
                    if (in_mode == MODE_START)
                    begin
                        cmd.start_load = 1'b1;
                        if (sts.empty)
                        begin
                            active_next = 1'b0;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            active_next = 1'b1;
                            state_next  = S_DIV;
                        end
                    end
                    else if (active_reg)
                    begin
                        cmd.out_pixel = 1'b1;
                        ov_next       = 1'b1;
                        if (sts.last)
                        begin
                            active_next = 1'b0;
                            state_next  = S_PIX;
                        end
                        else
                        begin
                            cmd.advance = 1'b1;
                            state_next  = S_IDX;
                            cmd.idx_start = 1'b0;
                        end
                    end
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.idx_start = 1'b1;
                    state_next    = S_WAIT;
                end
                else
                    cmd.div_step = 1'b1;
            end
            S_IDX:
            begin
                cmd.idx_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.idx_done)
                begin
                    if (!ov_reg || !out_stall)
                    begin
                        cmd.out_request = 1'b1;
                        ov_next         = 1'b1;
                        state_next      = S_SAMP;
                    end
                end
                else
                    cmd.idx_step = 1'b1;
            end
            S_PIX:
            begin
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
        if (state_reg == S_SAMP && !take)
            state_next = S_SAMP;
        if (state_reg == S_IDLE && !active_next)
            active_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            active_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            ov_reg     <= ov_next;
        end
    end

endmodule

FILE: hdl/rgb_channel_pack_nearest_resampler.sv
// Top level: nearest-neighbor RGB channel pack resampler.
// Usage:
//   Configure source sizes, present_mask and default_color over APB while idle.
//   A request with mode 0 starts a frame: scales are found by a bit-serial
//   divider (EW+SCALE_FRAC_BITS quotient bits, 29 by default), then the index
//   pipeline produces a read request (kind 0) with source indices.
//   The caller answers with mode 1 carrying fetched samples; the block returns
//   the composed pixel (kind 1) and, unless last_pixel, the next read request.
//   Per pixel, the time is set by the index multiply/clamp/multiply-add
//   pipeline plus the caller's fetch. Frame start adds the divider.
//   Input is stalled while a result still waits in the output register; the
//   output register holds until out_stall drops.
//   Reset sets source sizes to 1, present_mask and default_color to 0, block idle.
//   A start with no source present gives no result.
module rgb_channel_pack_nearest_resampler
    import rcpnr_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int SCALE_FRAC_BITS = SCALE_FB_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              mode,
    input  logic [7:0]        red_sample,
    input  logic [7:0]        green_sample,
    input  logic [7:0]        blue_sample,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              kind,
    output logic [23:0]       red_index,
    output logic [23:0]       green_index,
    output logic [23:0]       blue_index,
    output logic [7:0]        out_red,
    output logic [7:0]        out_green,
    output logic [7:0]        out_blue,
    output logic              last_pixel
);

    logic [DIM_W-1:0] sw_reg [NCH];
    logic [DIM_W-1:0] sh_reg [NCH];
    logic [2:0]       pm_reg;
    logic [23:0]      dc_reg;
    logic [2:0]       ra;

    assign pready = 1'b1;
    assign ra     = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                sw_reg[c] <= DIM_W'(1);
                sh_reg[c] <= DIM_W'(1);
            end
            pm_reg <= '0;
            dc_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'b00)
        begin
            case (ra)
                REG_RED_W:   sw_reg[0] <= pwdata[DIM_W-1:0];
                REG_RED_H:   sh_reg[0] <= pwdata[DIM_W-1:0];
                REG_GREEN_W: sw_reg[1] <= pwdata[DIM_W-1:0];
                REG_GREEN_H: sh_reg[1] <= pwdata[DIM_W-1:0];
                REG_BLUE_W:  sw_reg[2] <= pwdata[DIM_W-1:0];
                REG_BLUE_H:  sh_reg[2] <= pwdata[DIM_W-1:0];
                REG_PRESENT: pm_reg    <= pwdata[2:0];
                REG_DEFAULT: dc_reg    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ra)
            REG_RED_W:   prdata = 32'(sw_reg[0]);
            REG_RED_H:   prdata = 32'(sh_reg[0]);
            REG_GREEN_W: prdata = 32'(sw_reg[1]);
            REG_GREEN_H: prdata = 32'(sh_reg[1]);
            REG_BLUE_W:  prdata = 32'(sw_reg[2]);
            REG_BLUE_H:  prdata = 32'(sh_reg[2]);
            REG_PRESENT: prdata = 32'(pm_reg);
            REG_DEFAULT: prdata = 32'(dc_reg);
            default:     prdata = '0;
        endcase
    end

    rc_cmd_t cmd;
    rc_sts_t sts;

    rcpnr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_mode   (mode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    rcpnr_datapath #(
        .MAX_DIM         (MAX_DIM),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .src_w_raw    (sw_reg),
        .src_h_raw    (sh_reg),
        .present      (pm_reg),
        .dflt         (dc_reg),
        .red_sample   (red_sample),
        .green_sample (green_sample),
        .blue_sample  (blue_sample),
        .kind         (kind),
        .red_index    (red_index),
        .green_index  (green_index),
        .blue_index   (blue_index),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .last_pixel   (last_pixel)
    );

endmodule

FILE: hdl/rcpnr_checker.sv
// Checker: port-level assertions for the resampler, bound to the top level.
module rcpnr_checker
    import rcpnr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        kind,
    input logic [23:0] red_index,
    input logic        last_pixel,
    input logic        pready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(red_index))
        else $error("stalled result changed");

    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_pixel |-> kind == KIND_PIXEL)
        else $error("last_pixel on a request");

    a_no_take_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("request taken while result waits");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind rgb_channel_pack_nearest_resampler rcpnr_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (kind),
    .red_index  (red_index),
    .last_pixel (last_pixel),
    .pready     (pready)
);

FILE: dv/testbench.sv
// Testbench for the nearest-neighbor RGB channel pack resampler: directed table, then random frames.
module testbench;
    import rcpnr_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [23:0] ridx;
        logic [23:0] gidx;
        logic [23:0] bidx;
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic        last;
    } pixel_result_t;

    typedef struct {
        logic       mode;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       has_exp;
        logic       e_kind;
        logic [7:0] e_r;
        logic [7:0] e_g;
        logic [7:0] e_b;
        logic       e_last;
    } dir_row_t;

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_stall, mode;
    logic [7:0] red_sample, green_sample, blue_sample;
    logic out_valid, out_stall, kind, last_pixel;
    logic [23:0] red_index, green_index, blue_index;
    logic [7:0] out_red, out_green, out_blue;

    rgb_channel_pack_nearest_resampler uut (.*);

    // predictor state
    logic [12:0] src_w_reg [3];
    logic [12:0] src_h_reg [3];
    logic [2:0]  present_reg;
    logic [23:0] default_reg;
    int unsigned frm_w, frm_h, col_cnt, row_cnt;
    longint unsigned scl_x [3];
    longint unsigned scl_y [3];
    bit          frm_active;

    pixel_result_t pending_results [$];
    pixel_result_t typed_results [$];
    bit  failed;
    bit  calm;
    bit  hold_off;
    int  results_seen;

    initial begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial begin
        #40000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int unsigned eff_dim(logic [12:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return v;
    endfunction

    function automatic logic [23:0] source_index(int c);
        longint unsigned sw, sh, sx, sy;
        sw = eff_dim(src_w_reg[c]);
        sh = eff_dim(src_h_reg[c]);
        sx = (longint'(col_cnt) * scl_x[c]) >> SCALE_FB_DEF;
        sy = (longint'(row_cnt) * scl_y[c]) >> SCALE_FB_DEF;
        if (sx >= sw) sx = sw - 1;
        if (sy >= sh) sy = sh - 1;
        return 24'(sy * sw + sx);
    endfunction

    function automatic pixel_result_t read_request();
        pixel_result_t q;
        q = '0;
        q.kind = KIND_REQUEST;
        q.ridx = present_reg[0] ? source_index(0) : 24'd0;
        q.gidx = present_reg[1] ? source_index(1) : 24'd0;
        q.bidx = present_reg[2] ? source_index(2) : 24'd0;
        return q;
    endfunction

    task automatic predict_pixel(logic m, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pixel_result_t q;
        int unsigned w, h;
        bit lst;
        if (m == MODE_START) begin
            w = 0;
            h = 0;
            for (int c = 0; c < 3; c++)
                if (present_reg[c]) begin
                    if (eff_dim(src_w_reg[c]) > w) w = eff_dim(src_w_reg[c]);
                    if (eff_dim(src_h_reg[c]) > h) h = eff_dim(src_h_reg[c]);
                end
            frm_w = w;
            frm_h = h;
            col_cnt = 0;
            row_cnt = 0;
            if (w == 0) begin
                frm_active = 0;
                return;
            end
            for (int c = 0; c < 3; c++) begin
                scl_x[c] = (longint'(eff_dim(src_w_reg[c])) << SCALE_FB_DEF) / w;
                scl_y[c] = (longint'(eff_dim(src_h_reg[c])) << SCALE_FB_DEF) / h;
            end
            frm_active = 1;
            pending_results.push_back(read_request());
            return;
        end
        if (!frm_active) return;
        lst = (col_cnt + 1 >= frm_w) && (row_cnt + 1 >= frm_h);
        q = '0;
        q.kind = KIND_PIXEL;
        q.r = present_reg[0] ? r : default_reg[23:16];
        q.g = present_reg[1] ? g : default_reg[15:8];
        q.b = present_reg[2] ? b : default_reg[7:0];
        q.last = lst;
        pending_results.push_back(q);
        if (lst) begin
            frm_active = 0;
            col_cnt = 0;
            row_cnt = 0;
            return;
        end
        col_cnt++;
        if (col_cnt >= frm_w) begin
            col_cnt = 0;
            row_cnt++;
        end
        pending_results.push_back(read_request());
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        in_valid <= 0;
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_RED_W:   src_w_reg[0] = val[12:0];
            REG_RED_H:   src_h_reg[0] = val[12:0];
            REG_GREEN_W: src_w_reg[1] = val[12:0];
            REG_GREEN_H: src_h_reg[1] = val[12:0];
            REG_BLUE_W:  src_w_reg[2] = val[12:0];
            REG_BLUE_H:  src_h_reg[2] = val[12:0];
            REG_PRESENT: present_reg = val[2:0];
            default:     default_reg = val[23:0];
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        in_valid <= 0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge clk);
            guard++;
        end
        if (guard >= 200000) begin
            $display("Test completed with failures");
            $finish;
        end
        repeat (60) @(posedge clk);
    endtask

    task automatic send_request(logic m, logic [7:0] r, logic [7:0] g, logic [7:0] b);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1;
        mode <= m;
        red_sample <= r;
        green_sample <= g;
        blue_sample <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_pixel(m, r, g, b);
    endtask

    task automatic run_frame(int noise);
        int n;
        send_request(MODE_START, 8'($urandom), 8'($urandom), 8'($urandom));
        n = 0;
        while (frm_active && n < 300) begin
            if ($urandom_range(0, 99) < noise)
                send_request(MODE_START, 8'($urandom), 8'($urandom), 8'($urandom));
            else
                send_request(MODE_SAMPLES, 8'($urandom), 8'($urandom), 8'($urandom));
            n++;
        end
        if ($urandom_range(0, 3) == 0)
            send_request(MODE_SAMPLES, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // output stall process
    initial begin
        out_stall = 0;
        @(posedge rst_n);
        forever begin
            if (hold_off) begin
                out_stall <= 1;
                repeat (400) @(posedge clk);
                out_stall <= 0;
                hold_off = 0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                out_stall <= 1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 0;
            end
            @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk) begin
        pixel_result_t got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = {kind, red_index, green_index, blue_index, out_red, out_green, out_blue,
                   last_pixel};
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                failed = 1;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    failed = 1;
                end
                if (typed_results.size() != 0) begin
                    want = typed_results.pop_front();
                    if (got.kind !== want.kind || got.r !== want.r || got.g !== want.g ||
                        got.b !== want.b || got.last !== want.last) begin
                        $display("%0t: table mismatch expected %h actual %h", $time, want, got);
                        failed = 1;
                    end
                end
            end
        end
    end

    initial begin
        dir_row_t tbl [$];
        int cfg;
        logic [12:0] dims [6];
        failed = 0;
        calm = 0;
        hold_off = 0;
        results_seen = 0;
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_valid = 0;
        mode = 0;
        red_sample = 0;
        green_sample = 0;
        blue_sample = 0;
        for (int c = 0; c < 3; c++) begin
            src_w_reg[c] = 1;
            src_h_reg[c] = 1;
            scl_x[c] = 0;
            scl_y[c] = 0;
        end
        present_reg = 0;
        default_reg = 0;
        frm_w = 0;
        frm_h = 0;
        col_cnt = 0;
        row_cnt = 0;
        frm_active = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // after reset: no source, start and samples give nothing
        tbl.push_back('{MODE_START, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0});
        tbl.push_back('{MODE_SAMPLES, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 0, 0, 0});
        foreach (tbl[i]) send_request(tbl[i].mode, tbl[i].r, tbl[i].g, tbl[i].b);
        wait_idle();

        // 1x1 red only, default colour extremes
        reg_write(REG_PRESENT, 32'h1);
        reg_write(REG_DEFAULT, 32'hFF00A5);
        tbl.delete();
        tbl.push_back('{MODE_START, 8'h00, 8'h00, 8'h00, 1, KIND_REQUEST, 0, 0, 0, 0});
        tbl.push_back('{MODE_SAMPLES, 8'h00, 8'h12, 8'h34, 1, KIND_PIXEL, 8'h00, 8'h00,
                        8'hA5, 1});
        tbl.push_back('{MODE_SAMPLES, 8'h55, 8'h55, 8'h55, 0, 0, 0, 0, 0, 0});
        tbl.push_back('{MODE_START, 8'h00, 8'h00, 8'h00, 1, KIND_REQUEST, 0, 0, 0, 0});
        tbl.push_back('{MODE_SAMPLES, 8'hFF, 8'hAA, 8'h55, 1, KIND_PIXEL, 8'hFF, 8'h00,
                        8'hA5, 1});
        foreach (tbl[i]) begin
            if (tbl[i].has_exp)
                typed_results.push_back('{tbl[i].e_kind, 24'd0, 24'd0, 24'd0, tbl[i].e_r,
                                          tbl[i].e_g, tbl[i].e_b, tbl[i].e_last});
            else if (tbl[i].mode == MODE_SAMPLES || present_reg == 0)
                ;
            send_request(tbl[i].mode, tbl[i].r, tbl[i].g, tbl[i].b);
        end
        wait_idle();

        // sizes: zero, 4096 and above, mixed sources, abandoned frame
        reg_write(REG_PRESENT, 32'h7);
        reg_write(REG_DEFAULT, 32'h00FF00);
        reg_write(REG_RED_W, 32'd0);
        reg_write(REG_RED_H, 32'd3);
        reg_write(REG_GREEN_W, 32'd2);
        reg_write(REG_GREEN_H, 32'd0);
        reg_write(REG_BLUE_W, 32'd3);
        reg_write(REG_BLUE_H, 32'd2);
        tbl.delete();
        tbl.push_back('{MODE_START, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0});
        tbl.push_back('{MODE_SAMPLES, 8'h01, 8'h02, 8'h03, 0, 0, 0, 0, 0, 0});
        tbl.push_back('{MODE_START, 8'h00, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0});
        for (int i = 0; i < 9; i++)
            tbl.push_back('{MODE_SAMPLES, 8'(i * 29), 8'(255 - i), 8'(i), 0, 0, 0, 0, 0, 0});
        foreach (tbl[i]) send_request(tbl[i].mode, tbl[i].r, tbl[i].g, tbl[i].b);
        wait_idle();

        reg_write(REG_RED_W, 32'h1FFF);
        reg_write(REG_RED_H, 32'd1);
        reg_write(REG_GREEN_W, 32'd4096);
        reg_write(REG_PRESENT, 32'h3);
        send_request(MODE_START, 0, 0, 0);
        for (int i = 0; i < 6; i++)
            send_request(MODE_SAMPLES, 8'($urandom), 8'($urandom), 8'($urandom));
        send_request(MODE_START, 0, 0, 0);
        wait_idle();

        // random frames with several settings
        cfg = 0;
        while (cfg < 120) begin
            for (int i = 0; i < 6; i++)
                case ($urandom_range(0, 9))
                    0: dims[i] = 0;
                    1: dims[i] = 13'h1FFF;
                    2: dims[i] = 13'($urandom);
                    default: dims[i] = 13'($urandom_range(1, 5));
                endcase
            // keep frames small: a channel with either size above 8 gets new sizes of 1 to 6
            for (int c = 0; c < 3; c++)
                if (eff_dim(dims[2 * c]) > 8 || eff_dim(dims[2 * c + 1]) > 8) begin
                    dims[2 * c] = 13'($urandom_range(1, 6));
                    dims[2 * c + 1] = 13'($urandom_range(1, 6));
                end
            if (cfg % 40 == 3) begin
                dims[0] = 13'h1FFF;
                dims[1] = 13'd1;
                dims[2] = 13'd1;
                dims[3] = 13'd1;
                dims[4] = 13'd1;
                dims[5] = 13'd1;
            end
            reg_write(REG_RED_W, 32'(dims[0]));
            reg_write(REG_RED_H, 32'(dims[1]));
            reg_write(REG_GREEN_W, 32'(dims[2]));
            reg_write(REG_GREEN_H, 32'(dims[3]));
            reg_write(REG_BLUE_W, 32'(dims[4]));
            reg_write(REG_BLUE_H, 32'(dims[5]));
            reg_write(REG_PRESENT, 32'((cfg % 40 == 3) ? 3'b001 : 3'($urandom)));
            reg_write(REG_DEFAULT, $urandom);
            if (cfg == 20) hold_off = 1;
            if (cfg >= 105) calm = 1;
            if (cfg % 40 == 3) begin
                // one row of 4096: only start and a handful of pixels, then abandon
                send_request(MODE_START, 0, 0, 0);
                for (int i = 0; i < 8; i++)
                    send_request(MODE_SAMPLES, 8'($urandom), 8'($urandom), 8'($urandom));
                wait_idle();
                reg_write(REG_PRESENT, 32'h0);
                send_request(MODE_START, 0, 0, 0);
            end else begin
                run_frame((cfg % 4 == 0) ? 3 : 0);
            end
            wait_idle();
            cfg++;
        end

        if (!failed && pending_results.size() == 0 && typed_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
